// ===== rtl/kld_pkg.sv =====
// Shared types and constants for the keyed record list.
// No dependencies; imported by kld_cell and the top level.
package kld_pkg;

	localparam int KEY_W   = 40;
	localparam int ID_W    = 44;
	localparam int GRADE_W = 10;
	localparam int ABS_W   = 8;
	localparam int OUT_W   = 5;

	localparam logic ACT_APPEND = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [ID_W-1:0]    id;
		logic [GRADE_W-1:0] grade;
		logic [ABS_W-1:0]   absences;
	} rec_t;

	// one command word broadcast to every cell
	typedef struct packed {
		logic load;
		logic mark;
		logic step;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPACT,
		ST_DONE
	} st_t;

endpackage

// ===== rtl/kld_cell.sv =====
// One slot of the record chain: holds a record and an occupied flag.
// Uses kld_pkg. Compaction moves records one slot down per step.
module kld_cell #(
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kld_pkg::cell_ctl_t ctl,
	input  kld_pkg::rec_t     in_rec,
	input  logic [CNT_W-1:0]  cnt,
	input  kld_pkg::rec_t     up_rec,
	input  logic              up_occ,
	input  logic              down_occ,
	output kld_pkg::rec_t     rec,
	output logic              occ,
	output logic              hit
);
	import kld_pkg::*;

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	rec_t rec_q;
	logic occ_q;
	logic held;

	assign held = MY_IDX < cnt;
	assign hit  = held && (rec_q.key == in_rec.key);
	assign rec  = rec_q;
	assign occ  = occ_q;

	always_ff @(posedge clk) begin
		if (ctl.load && (cnt == MY_IDX)) begin
			rec_q <= in_rec;
		end else if (ctl.step && !occ_q) begin
			rec_q <= up_rec;
		end
	end

	// an empty slot pulls from above; a full slot over an empty one gives its record away
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.mark) begin
			occ_q <= held && !hit;
		end else if (ctl.step) begin
			if (!occ_q) begin
				occ_q <= up_occ;
			end else if (!down_occ) begin
				occ_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/keyed_list_append_delete_top.sv =====
// Keyed record list: a chain of CAPACITY cells, each holding one record.
// An append word: the cell at the current count loads the record.
// A delete word: all cells compare the key at accept, then CAPACITY compaction
// steps slide survivors down one slot per step while a shifted hit vector counts
// removals, then the result is loaded once the result slot is free. The number
// of compaction steps is set by the chain length. Uses kld_pkg and kld_cell.
module keyed_list_append_delete_top #(
	parameter int CAPACITY  = 16,
	parameter int KEY_CHARS = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       action,
	input  logic [kld_pkg::KEY_W-1:0]  course_key,
	input  logic [kld_pkg::ID_W-1:0]   student_id,
	input  logic [kld_pkg::GRADE_W-1:0] grade,
	input  logic [kld_pkg::ABS_W-1:0]  absences,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       success,
	output logic                       full_refused,
	output logic [kld_pkg::OUT_W-1:0]  entry_count
);
	import kld_pkg::*;

	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int STEP_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int KEY_BITS = (KEY_CHARS * 8 > KEY_W) ? KEY_W : KEY_CHARS * 8;
	localparam logic [KEY_W-1:0]  KEY_MASK  = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);

	st_t st_q, st_d;
	cell_ctl_t ctl;
	rec_t in_rec;
	rec_t rec_w [CAPACITY];
	logic [CAPACITY-1:0] occ_w;
	logic [CAPACITY-1:0] hit_w;
	logic [CAPACITY-1:0] hit_q;
	logic [CNT_W-1:0] cnt_q, surv_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W+OUT_W-1:0] cnt_ext;
	logic ok_q, out_valid_q, success_q, refused_q;
	logic out_free, full, append_fire, done_load;

	assign in_rec.key      = course_key & KEY_MASK;
	assign in_rec.id       = student_id;
	assign in_rec.grade    = grade;
	assign in_rec.absences = absences;

	assign out_free = !out_valid_q || out_ready;
	assign full     = cnt_q == FULL_CNT;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rec_t up_rec;
		logic up_occ;
		logic down_occ;

		if (i == CAPACITY - 1) begin : g_top
			assign up_rec = rec_w[i];
			assign up_occ = 1'b0;
		end else begin : g_mid
			assign up_rec = rec_w[i+1];
			assign up_occ = occ_w[i+1];
		end

		if (i == 0) begin : g_head
			assign down_occ = 1'b1;
		end else begin : g_body
			assign down_occ = occ_w[i-1];
		end

		kld_cell #(
			.CNT_W(CNT_W),
			.IDX  (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.in_rec  (in_rec),
			.cnt     (cnt_q),
			.up_rec  (up_rec),
			.up_occ  (up_occ),
			.down_occ(down_occ),
			.rec     (rec_w[i]),
			.occ     (occ_w[i]),
			.hit     (hit_w[i])
		);
	end

	always_comb begin
		st_d        = st_q;
		ctl         = '0;
		in_ready    = 1'b0;
		append_fire = 1'b0;
		done_load   = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					if (action == ACT_APPEND) begin
						ctl.load    = 1'b1;
						append_fire = 1'b1;
					end else begin
						ctl.mark = 1'b1;
						st_d     = ST_COMPACT;
					end
				end
			end
			ST_COMPACT: begin
				ctl.step = 1'b1;
				if (step_q == LAST_STEP) begin
					st_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					done_load = 1'b1;
					st_d      = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			surv_q      <= '0;
			step_q      <= '0;
			hit_q       <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (append_fire || done_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (append_fire && !full) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (done_load) begin
				cnt_q <= surv_q;
			end
			if (ctl.mark) begin
				hit_q  <= hit_w;
				surv_q <= cnt_q;
				ok_q   <= 1'b0;
				step_q <= '0;
			end else if (ctl.step) begin
				hit_q  <= hit_q >> 1;
				step_q <= step_q + 1'b1;
				if (hit_q[0]) begin
					surv_q <= surv_q - 1'b1;
					ok_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (append_fire) begin
			success_q <= !full;
			refused_q <= full;
		end else if (done_load) begin
			success_q <= ok_q;
			refused_q <= 1'b0;
		end
	end

	// count register doubles as the result count: it only moves when a new word is loaded
	assign cnt_ext      = {{OUT_W{1'b0}}, cnt_q};
	assign entry_count  = cnt_ext[OUT_W-1:0];
	assign out_valid    = out_valid_q;
	assign success      = success_q;
	assign full_refused = refused_q;

endmodule

// ===== rtl/kld_checker.sv =====
// Port-level checks for the keyed record list, bound to the top level.
// No package dependency.
module kld_checker #(
	parameter int CAPACITY = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       success,
	input logic       full_refused,
	input logic [4:0] entry_count
);
	localparam logic [4:0] CAP_LOW = 5'(CAPACITY);

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(success && full_refused))
		else $error("success and full_refused both set");

	a_refused_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && full_refused) |-> (entry_count == CAP_LOW))
		else $error("append refused while list not full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CAPACITY >= 32 || entry_count <= CAP_LOW))
		else $error("entry count above capacity");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(entry_count)))
		else $error("stalled result word changed");

	// a new word only goes in when the result slot frees up
	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (!out_valid || out_ready))
		else $error("word accepted while result word stalled");

endmodule

bind keyed_list_append_delete_top kld_checker #(
	.CAPACITY(CAPACITY)
) u_kld_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.success     (success),
	.full_refused(full_refused),
	.entry_count (entry_count)
);
